// ----- rtl/core/aesm_pkg.sv -----
// ----------------------------------------------------------------------------
// aesm_pkg
// Shared types and constants for the static-model arithmetic encoder.
// ----------------------------------------------------------------------------
package aesm_pkg;

    // Fixed table and result buffer geometry
    localparam int TableDepth = 258;
    localparam int TblAw      = 9;
    localparam int MaxOut     = 36;
    localparam int OutAw      = 6;
    localparam logic [TblAw-1:0] EndSymbol = 9'd257;

    // Function codes
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_DATA = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  symbol_byte;
        logic [8:0]  table_index;
        logic [13:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_in_run;
        logic       end_of_stream;
        logic       follow_overflow;
    } t_out_item;

    // Table read address select
    typedef enum logic [1:0] {
        TSEL_TOTAL,
        TSEL_HI,
        TSEL_LO
    } t_tsel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TOT,
        ST_RD_HI,
        ST_RD_LO,
        ST_MUL,
        ST_DIV,
        ST_NARROW,
        ST_REN,
        ST_FOL,
        ST_FL_PUT,
        ST_FL_FOL,
        ST_FL_BYTE,
        ST_OUT,
        ST_OUT_LD
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic  start;
        t_tsel tsel;
        logic  cap_total;
        logic  cap_hi;
        logic  mul;
        logic  div_step;
        logic  narrow;
        logic  ren_step;
        logic  fol_step;
        logic  fl_put;
        logic  fl_byte;
        logic  out_ld;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic tot_zero;
        logic div_done;
        logic ren_done;
        logic ren_fol;
        logic fol_last;
        logic out_more;
        logic out_free;
        logic is_flush;
    } t_status;

endpackage

// ----- rtl/core/aesm_ram.sv -----
// ----------------------------------------------------------------------------
// aesm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module aesm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/aesm_ctrl.sv -----
// ----------------------------------------------------------------------------
// aesm_ctrl
// Sequencer: table reads, multiply, divide, renormalize, flush, byte drain.
// ----------------------------------------------------------------------------
module aesm_ctrl
    import aesm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic [1:0] i_func,
    input  t_status i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.tsel = TSEL_TOTAL;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && (i_func == FUNC_DATA || i_func == FUNC_END)) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_RD_TOT;
                end
            end
            ST_RD_TOT: begin
                o_cmd.tsel = TSEL_TOTAL;
                n_state    = ST_RD_HI;
            end
            ST_RD_HI: begin
                o_cmd.cap_total = 1'b1;
                o_cmd.tsel      = TSEL_HI;
                n_state         = ST_RD_LO;
            end
            ST_RD_LO: begin
                o_cmd.cap_hi = 1'b1;
                o_cmd.tsel   = TSEL_LO;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                // zero total skips the narrowing step
                if (i_sts.tot_zero) begin
                    n_state = ST_REN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_NARROW;
                end
            end
            ST_NARROW: begin
                o_cmd.narrow = 1'b1;
                n_state      = ST_REN;
            end
            ST_REN: begin
                o_cmd.ren_step = 1'b1;
                if (i_sts.ren_done) begin
                    n_state = i_sts.is_flush ? ST_FL_PUT : ST_OUT;
                end else if (i_sts.ren_fol) begin
                    n_state = ST_FOL;
                end
            end
            ST_FOL: begin
                o_cmd.fol_step = 1'b1;
                if (i_sts.fol_last) begin
                    n_state = ST_REN;
                end
            end
            ST_FL_PUT: begin
                o_cmd.fl_put = 1'b1;
                n_state      = ST_FL_FOL;
            end
            ST_FL_FOL: begin
                o_cmd.fol_step = 1'b1;
                if (i_sts.fol_last) begin
                    n_state = ST_FL_BYTE;
                end
            end
            ST_FL_BYTE: begin
                o_cmd.fl_byte = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (!i_sts.out_more) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    n_state = ST_OUT_LD;
                end
            end
            ST_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = ST_OUT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/aesm_dp.sv -----
// ----------------------------------------------------------------------------
// aesm_dp
// Datapath: frequency table, interval registers, multiplier, two-lane
// restoring divider, bit packer, byte buffer and output register.
// ----------------------------------------------------------------------------
module aesm_dp
    import aesm_pkg::*;
#(
    parameter int CODE_BITS   = 16,
    parameter int FREQ_BITS   = 14,
    parameter int FOLLOW_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  logic      i_in_fire,
    input  t_cmd      i_cmd,
    output t_status   o_sts,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int CW  = CODE_BITS;
    localparam int WW  = CW + 1;
    localparam int PW  = WW + FREQ_BITS;
    localparam int DCW = $clog2(PW);
    localparam int RCW = $clog2(CW + 1);
    localparam logic [CW-1:0] Half = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] Qtr1 = {2'b01, {(CW-2){1'b0}}};
    localparam logic [CW-1:0] Qtr3 = {2'b11, {(CW-2){1'b0}}};
    localparam logic [FOLLOW_BITS-1:0] FollowMax = {FOLLOW_BITS{1'b1}};
    localparam logic [DCW-1:0] DivLast = DCW'(PW - 1);
    localparam logic [RCW-1:0] RenMax  = RCW'(CW);
    localparam logic [OutAw-1:0] OutMax = OutAw'(MaxOut);

    // State
    logic [CW-1:0]          r_low, r_high;
    logic [FOLLOW_BITS-1:0] r_pend;
    logic [7:0]             r_pack;
    logic [3:0]             r_bleft;
    logic                   r_ovf;
    logic [TblAw-1:0]       r_sym;
    logic                   r_flush;
    logic [FREQ_BITS-1:0]   r_total, r_cum_hi;
    logic [PW-1:0]          r_qa, r_qb;
    logic [FREQ_BITS-1:0]   r_ra, r_rb;
    logic [DCW-1:0]         r_dcnt;
    logic [RCW-1:0]         r_rcnt;
    logic                   r_bit;
    logic [OutAw-1:0]       r_cnt, r_rptr;
    t_out_item              r_out;
    logic                   r_ovalid;

    // Frequency table
    logic                 tbl_we;
    logic [TblAw-1:0]     tbl_raddr;
    logic [FREQ_BITS-1:0] tbl_q;

    assign tbl_we = i_in_fire && i_in.func == FUNC_LOAD
                    && i_in.table_index < TblAw'(TableDepth);

    always_comb begin
        unique case (i_cmd.tsel)
            TSEL_HI: tbl_raddr = r_sym - TblAw'(1);
            TSEL_LO: tbl_raddr = r_sym;
            default: tbl_raddr = '0;
        endcase
    end

    aesm_ram #(.WIDTH(FREQ_BITS), .DEPTH(TableDepth)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_in.table_index),
        .i_wdata (i_in.table_value[FREQ_BITS-1:0]),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_q)
    );

    // Interval width and products
    logic [WW-1:0] width;
    logic [PW-1:0] prod_a, prod_b;
    assign width  = {1'b0, r_high - r_low} + WW'(1);
    assign prod_a = PW'(width) * PW'(r_cum_hi);
    assign prod_b = PW'(width) * PW'(tbl_q);

    // Divider lanes, one quotient bit per cycle
    logic [FREQ_BITS:0] rs_a, rs_b;
    logic               ge_a, ge_b;
    assign rs_a = {r_ra, r_qa[PW-1]};
    assign rs_b = {r_rb, r_qb[PW-1]};
    assign ge_a = rs_a >= {1'b0, r_total};
    assign ge_b = rs_b >= {1'b0, r_total};

    // Renormalization decision
    logic c_lo, c_hi, c_mid, do_step;
    assign c_lo    = r_high < Half;
    assign c_hi    = r_low >= Half;
    assign c_mid   = r_low >= Qtr1 && r_high < Qtr3;
    assign do_step = r_rcnt < RenMax && (c_lo || c_hi || c_mid);

    // Bit packer inputs
    logic put_en, put_val, bump_en;
    always_comb begin
        put_en  = 1'b0;
        put_val = 1'b0;
        bump_en = 1'b0;
        if (i_cmd.ren_step && do_step) begin
            put_en  = c_lo || c_hi;
            put_val = !c_lo;
            bump_en = !(c_lo || c_hi);
        end else if (i_cmd.fol_step) begin
            put_en  = 1'b1;
            put_val = !r_bit;
        end else if (i_cmd.fl_put) begin
            put_en  = 1'b1;
            put_val = !(r_low < Qtr1);
            bump_en = 1'b1;
        end
    end

    logic [7:0] pack_n;
    logic [3:0] bleft_dec;
    logic       byte_full;
    assign pack_n    = {put_val, r_pack[7:1]};
    assign bleft_dec = r_bleft - 4'd1;
    assign byte_full = put_en && bleft_dec == 4'd0;

    // Byte buffer
    logic [7:0] flush_byte, ob_wdata, ob_q;
    logic       ob_we;
    assign flush_byte = (r_bleft >= 4'd8) ? 8'd0 : (r_pack >> r_bleft);
    assign ob_wdata   = i_cmd.fl_byte ? flush_byte : pack_n;
    assign ob_we      = (byte_full || i_cmd.fl_byte) && r_cnt < OutMax;

    aesm_ram #(.WIDTH(8), .DEPTH(MaxOut)) u_obuf (
        .i_clk   (i_clk),
        .i_we    (ob_we),
        .i_waddr (r_cnt),
        .i_wdata (ob_wdata),
        .i_raddr (r_rptr),
        .o_rdata (ob_q)
    );

    // Renorm subtract before shift
    logic [CW-1:0] ls, hs;
    always_comb begin
        ls = r_low;
        hs = r_high;
        if (!c_lo && c_hi) begin
            ls = r_low - Half;
            hs = r_high - Half;
        end else if (!c_lo) begin
            ls = r_low - Qtr1;
            hs = r_high - Qtr1;
        end
    end

    // Control state of the coder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= '0;
            r_high   <= '1;
            r_pend   <= '0;
            r_pack   <= '0;
            r_bleft  <= 4'd8;
            r_ovf    <= 1'b0;
            r_cnt    <= '0;
            r_rptr   <= '0;
            r_rcnt   <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
            r_flush  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_flush <= i_in.func == FUNC_END;
                r_cnt   <= '0;
                r_rptr  <= '0;
                r_rcnt  <= '0;
            end
            if (i_cmd.mul) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DCW'(1);
            end
            if (i_cmd.narrow) begin
                r_high <= r_low + r_qa[CW-1:0] - CW'(1);
                r_low  <= r_low + r_qb[CW-1:0];
            end
            if (i_cmd.ren_step && do_step) begin
                r_low  <= {ls[CW-2:0], 1'b0};
                r_high <= {hs[CW-2:0], 1'b1};
                r_rcnt <= r_rcnt + RCW'(1);
            end
            // pending count
            if (bump_en) begin
                if (r_pend == FollowMax) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_pend <= r_pend + FOLLOW_BITS'(1);
                end
            end else if (i_cmd.fol_step) begin
                r_pend <= r_pend - FOLLOW_BITS'(1);
            end
            // packer
            if (put_en) begin
                r_pack  <= pack_n;
                r_bleft <= byte_full ? 4'd8 : bleft_dec;
            end
            if (ob_we) begin
                r_cnt <= r_cnt + OutAw'(1);
            end
            // restart after the final byte
            if (i_cmd.fl_byte) begin
                r_low   <= '0;
                r_high  <= '1;
                r_pend  <= '0;
                r_pack  <= '0;
                r_bleft <= 4'd8;
            end
            // output register
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
                r_rptr   <= r_rptr + OutAw'(1);
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sym <= (i_in.func == FUNC_END) ? EndSymbol
                                             : {1'b0, i_in.symbol_byte} + TblAw'(1);
        end
        if (i_cmd.cap_total) begin
            r_total <= tbl_q;
        end
        if (i_cmd.cap_hi) begin
            r_cum_hi <= tbl_q;
        end
        if (i_cmd.mul) begin
            r_qa <= prod_a;
            r_qb <= prod_b;
            r_ra <= '0;
            r_rb <= '0;
        end else if (i_cmd.div_step) begin
            r_qa <= {r_qa[PW-2:0], ge_a};
            r_qb <= {r_qb[PW-2:0], ge_b};
            r_ra <= ge_a ? FREQ_BITS'(rs_a - {1'b0, r_total}) : rs_a[FREQ_BITS-1:0];
            r_rb <= ge_b ? FREQ_BITS'(rs_b - {1'b0, r_total}) : rs_b[FREQ_BITS-1:0];
        end
        // follow bits all repeat the opposite of the bit that preceded them
        if (put_en && !i_cmd.fol_step) begin
            r_bit <= put_val;
        end
        if (i_cmd.out_ld) begin
            r_out.code_byte       <= ob_q;
            r_out.last_in_run     <= (r_rptr + OutAw'(1)) == r_cnt;
            r_out.end_of_stream   <= ((r_rptr + OutAw'(1)) == r_cnt) && r_flush;
            r_out.follow_overflow <= r_ovf;
        end
    end

    // Status
    assign o_sts.tot_zero = r_total == '0;
    assign o_sts.div_done = r_dcnt == DivLast;
    assign o_sts.ren_done = !do_step;
    assign o_sts.ren_fol  = do_step && (c_lo || c_hi) && r_pend != '0;
    assign o_sts.fol_last = r_pend == FOLLOW_BITS'(1);
    assign o_sts.out_more = r_rptr != r_cnt;
    assign o_sts.out_free = !r_ovalid || i_ready;
    assign o_sts.is_flush = r_flush;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

// ----- rtl/core/arithmetic_encoder_static_model.sv -----
// Sequence: a load or ignored item is taken in the idle state. A coded item goes through
// table reads, multiply, a bit-serial divide and narrowing (a zero total skips divide
// and narrowing), then renormalization shifts and pending bits, the flush of an end
// item, and the drain of the result bytes through the output register.
// One item at a time: a new item is taken only in idle, after the result bytes drain.
// Reset (synchronous, active low) clears coder state and flags, not the table.
// ----------------------------------------------------------------------------
// arithmetic_encoder_static_model
// Static-model 16-bit arithmetic encoder top level.
// ----------------------------------------------------------------------------
module arithmetic_encoder_static_model
    import aesm_pkg::*;
#(
    parameter int CODE_BITS   = 16,
    parameter int FREQ_BITS   = 14,
    parameter int FOLLOW_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cmd    cmd;
    t_status sts;
    logic    in_fire;

    assign in_fire = i_in_valid && o_in_ready;

    aesm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    aesm_dp #(
        .CODE_BITS   (CODE_BITS),
        .FREQ_BITS   (FREQ_BITS),
        .FOLLOW_BITS (FOLLOW_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in_data),
        .i_in_fire (in_fire),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule

// ----- rtl/core/aesm_chk.sv -----
// ----------------------------------------------------------------------------
// aesm_chk
// Port-level checks for the arithmetic encoder, bound to the top level.
// ----------------------------------------------------------------------------
module aesm_chk
    import aesm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // End of stream only on the last byte of a run
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_stream |-> o_out_data.last_in_run)
        else $error("end_of_stream without last_in_run");

    // A new result appears only while draining, never while taking input
    a_rose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready)
        else $error("result appeared while idle");

    // Reset clears the output
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind arithmetic_encoder_static_model aesm_chk u_aesm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
